// ===== rtl/ksrlp_pkg.sv =====
package ksrlp_pkg;

  localparam int unsigned ScanPeriodW = 8;
  localparam int unsigned LongPressW  = 16;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [ScanPeriodW-1:0] ScanPeriodRst = 8'd20;
  localparam logic [LongPressW-1:0]  LongPressRst  = 16'd1000;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] REG_SCAN_PERIOD = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS  = 1'b1;

  // item mode
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // sampled key state, also used as key code
  typedef enum logic [2:0] {
    KS_NONE       = 3'd0,
    KS_KEY1       = 3'd1,
    KS_KEY2       = 3'd2,
    KS_KEY3_SHORT = 3'd3,
    KS_KEY3_LONG  = 3'd4
  } key_state_e;

  typedef struct packed {
    logic mode;
    logic key1_level;
    logic key2_level;
    logic key3_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0] key_code;
    logic [2:0] scan_state;
  } out_item_t;

endpackage

// ===== rtl/ksrlp_if.sv =====
interface ksrlp_in_if
  import ksrlp_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ksrlp_out_if
  import ksrlp_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/key_scan_release_long_press_core.sv =====
// Key scanner with release latching and long-press detect on key three.
// A result is registered in the output register, or in the skid register while the output stalls.
// Throughput: one item per cycle; a two-deep output stage (result register
// plus skid register) keeps the input open for one item while a result stalls.
// Reset (rst_ni, async, active low): counters and states clear, scan period 20,
// long-press threshold 1000, no result pending.
module key_scan_release_long_press_core
  import ksrlp_pkg::*;
#(
  parameter int unsigned HOLD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  ksrlp_in_if.sink            in_i,
  ksrlp_out_if.source         out_o
);

  localparam int unsigned CmpW = (HOLD_BITS > LongPressW) ? HOLD_BITS : LongPressW;
  localparam logic [HOLD_BITS-1:0] HoldMax = {HOLD_BITS{1'b1}};

  logic [ScanPeriodW-1:0] scan_period_q;
  logic [LongPressW-1:0]  long_press_q;

  logic [ScanPeriodW-1:0] tick_q, tick_d, tick_inc;
  logic [HOLD_BITS-1:0]   hold_q, hold_d;
  key_state_e             prev_q, prev_d, cur_q, cur_d, pend_q, pend_d, sampled;
  logic                   do_sample, is_long;

  out_item_t result;
  out_item_t out_q, out_d, skid_q, skid_d;
  logic      out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic      in_fire, out_fire;

  assign in_i.ready  = ~skid_valid_q;
  assign in_fire     = in_i.valid & in_i.ready;
  assign out_fire    = out_valid_q & out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_period_q <= ScanPeriodRst;
      long_press_q  <= LongPressRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCAN_PERIOD: scan_period_q <= cfg_wdata_i[ScanPeriodW-1:0];
        REG_LONG_PRESS:  long_press_q  <= cfg_wdata_i[LongPressW-1:0];
        default: ;
      endcase
    end
  end

  // item processing; hold counter updates before the sample in the same tick
  always_comb begin
    hold_d    = hold_q;
    tick_d    = tick_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    pend_d    = pend_q;
    tick_inc  = tick_q + ScanPeriodW'(1);
    do_sample = 1'b0;
    sampled   = KS_NONE;
    is_long   = 1'b0;

    if (in_i.data.mode == MODE_READ) begin
      pend_d = KS_NONE;
    end else begin
      if (!in_i.data.key3_level) begin
        if (hold_q != HoldMax) hold_d = hold_q + HOLD_BITS'(1);
      end else begin
        hold_d = '0;
      end

      is_long = CmpW'(hold_d) >= CmpW'(long_press_q);
      if (!in_i.data.key1_level)      sampled = KS_KEY1;
      else if (!in_i.data.key2_level) sampled = KS_KEY2;
      else if (!in_i.data.key3_level) sampled = is_long ? KS_KEY3_LONG : KS_KEY3_SHORT;
      else                            sampled = KS_NONE;

      tick_d    = tick_inc;
      do_sample = tick_inc >= scan_period_q;
      if (do_sample) begin
        tick_d = '0;
        prev_d = cur_q;
        cur_d  = sampled;
        if (cur_q != KS_NONE && sampled == KS_NONE) pend_d = cur_q;
      end
    end

    result.key_code   = (in_i.data.mode == MODE_READ) ? pend_q : KS_NONE;
    result.scan_state = cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      hold_q <= '0;
      prev_q <= KS_NONE;
      cur_q  <= KS_NONE;
      pend_q <= KS_NONE;
    end else if (in_fire) begin
      tick_q <= tick_d;
      hold_q <= hold_d;
      prev_q <= prev_d;
      cur_q  <= cur_d;
      pend_q <= pend_d;
    end
  end

  // output register with skid stage
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // prev_q mirrors the sample before last; kept as part of the scan state
  logic unused_prev;
  assign unused_prev = ^prev_q;

endmodule

// ===== rtl/ksrlp_checker.sv =====
module ksrlp_checker
  import ksrlp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // codes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.key_code <= 3'd4 && out_data_i.scan_state <= 3'd4)
    else $error("code out of range");

  // input only closes while both output slots are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  // item into an empty block shows up next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> out_valid_i)
    else $error("result lost");

  // no result without an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_i) && !out_valid_i |=> !out_valid_i)
    else $error("result invented");

endmodule

bind key_scan_release_long_press_core ksrlp_checker u_ksrlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
